>>> rtl/min_max_heap_queue_macros.svh
// Assertion macros shared by the checker
`ifndef MIN_MAX_HEAP_QUEUE_MACROS_SVH
`define MIN_MAX_HEAP_QUEUE_MACROS_SVH

// same-cycle implication
`define MMHQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("min_max_heap_queue: check failed");

// next-cycle implication
`define MMHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("min_max_heap_queue: check failed");

`endif

>>> rtl/mmhq_pkg.sv
`default_nettype none
package mmhq_pkg;
	localparam int CAPACITY = 128;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CAND_W   = IDX_W + 3;
	localparam int ENT_W    = 64;

	typedef enum logic [1:0] {
		FN_INS  = 2'd0,
		FN_DMIN = 2'd1,
		FN_DMAX = 2'd2,
		FN_NOP  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [17:0] {
		S_IDLE  = 18'h00001,
		S_CL_P  = 18'h00002,
		S_CL_PD = 18'h00004,
		S_CL_G  = 18'h00008,
		S_CL_GD = 18'h00010,
		S_D_R1  = 18'h00020,
		S_D_R2  = 18'h00040,
		S_D_C12 = 18'h00080,
		S_D_RH  = 18'h00100,
		S_D_HD  = 18'h00200,
		S_D_RL  = 18'h00400,
		S_D_LD  = 18'h00800,
		S_SK_IN = 18'h01000,
		S_SK_RD = 18'h02000,
		S_SK_DT = 18'h04000,
		S_SK_DC = 18'h08000,
		S_SK_WP = 18'h10000,
		S_SK_FN = 18'h20000
	} state_t;

	// even depth of a tree position means a min level
	function automatic logic is_min_level(input logic [IDX_W-1:0] i);
		logic [IDX_W:0] v;
		logic           par;
		v   = {1'b0, i} + {{IDX_W{1'b0}}, 1'b1};
		par = 1'b0;
		for (int b = 0; b <= IDX_W; b++) begin
			if (v[b]) par = b[0];
		end
		return ~par;
	endfunction
endpackage
`default_nettype wire

>>> rtl/min_max_heap_queue.sv
`default_nettype none
// Min-max heap priority queue of up to 128 tag/score entries. Issue a word with start while
// busy is low; the result appears for exactly one cycle with done high and cannot be held
// off, so capture it then. Refused and no-op words answer straight from idle, inserts climb
// by a parent check and then grandparent steps, and deletes pick (for a max) and fetch the
// removed and the last entry, then sink the last entry, reading and comparing one candidate
// at a time through children and grandchildren, with at most three grandchild steps and a
// final check on a full store. Every entry is fetched through the single registered read
// port of the store, one candidate at a time, and judged by one shared score comparator.
module min_max_heap_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  func,
	input  wire logic [31:0] tag,
	input  wire logic signed [31:0] score,
	output logic             done,
	output logic [1:0]       status,
	output logic [31:0]      out_tag,
	output logic signed [31:0] out_score,
	output logic [7:0]       count
);
	localparam int IW = mmhq_pkg::IDX_W;
	localparam int CW = mmhq_pkg::CNT_W;
	localparam int DW = mmhq_pkg::CAND_W;

	mmhq_pkg::state_t state_q;
	logic [63:0]   x_q, best_val_q, ch0_q, ch1_q, fixv_q, ot_q;
	logic [IW-1:0] pos_q, hole_q, best_idx_q, fixp_q;
	logic [CW-1:0] cnt_q, res_cnt_q;
	logic [31:0]   k1_q;
	logic [2:0]    k_q, best_k_q;
	logic          mode_max_q, is_min_q, best_self_q;
	logic          done_q;
	logic [1:0]    res_status_q;
	logic [63:0]   res_val_q;

	logic          we;
	logic [IW-1:0] wr_addr, rd_addr;
	logic [63:0]   wr_data, rd_data;
	logic signed [31:0] cmp_a, cmp_b;
	logic          cmp_max, beats;
	logic [IW-1:0] par_idx, gp_idx;
	logic [DW-1:0] cand;
	logic          cand_in;
	logic [63:0]   par_val;

	assign par_idx = (pos_q - IW'(1)) >> 1;
	assign gp_idx  = (pos_q - IW'(3)) >> 2;
	assign cand    = (k_q < 3'd2) ? ((DW'(pos_q) << 1) + DW'(1) + DW'(k_q))
	                              : ((DW'(pos_q) << 2) + DW'(1) + DW'(k_q));
	assign cand_in = cand < DW'(cnt_q);
	assign par_val = best_k_q[2] ? ch1_q : ch0_q;

	mmhq_ram #(.WIDTH(mmhq_pkg::ENT_W), .DEPTH(mmhq_pkg::CAPACITY)) u_ram (
		.clk, .we, .wr_addr, .wr_data, .rd_addr, .rd_data
	);

	mmhq_cmp u_cmp (.a(cmp_a), .b(cmp_b), .want_max(cmp_max), .beats);

	always_comb begin
		rd_addr = '0;
		we      = 1'b0;
		wr_addr = pos_q;
		wr_data = x_q;
		cmp_a   = x_q[31:0];
		cmp_b   = rd_data[31:0];
		cmp_max = 1'b0;
		unique case (state_q)
			mmhq_pkg::S_CL_P:  rd_addr = par_idx;
			mmhq_pkg::S_CL_PD: begin
				cmp_max = mmhq_pkg::is_min_level(pos_q);
				we      = beats;
				wr_data = rd_data;
			end
			mmhq_pkg::S_CL_G: begin
				rd_addr = gp_idx;
				we      = pos_q < IW'(3);
			end
			mmhq_pkg::S_CL_GD: begin
				cmp_max = mode_max_q;
				we      = 1'b1;
				wr_data = beats ? rd_data : x_q;
			end
			mmhq_pkg::S_D_R1:  rd_addr = IW'(1);
			mmhq_pkg::S_D_R2:  rd_addr = IW'(2);
			mmhq_pkg::S_D_C12: begin
				cmp_a   = k1_q;
				cmp_max = 1'b1;
			end
			mmhq_pkg::S_D_RH:  rd_addr = hole_q;
			mmhq_pkg::S_D_RL:  rd_addr = IW'(cnt_q - CW'(1));
			mmhq_pkg::S_SK_RD: rd_addr = cand[IW-1:0];
			mmhq_pkg::S_SK_DT: begin
				cmp_a   = rd_data[31:0];
				cmp_b   = best_val_q[31:0];
				cmp_max = ~is_min_q;
			end
			mmhq_pkg::S_SK_DC: begin
				cmp_b   = par_val[31:0];
				cmp_max = is_min_q;
				we      = 1'b1;
				wr_data = best_self_q ? x_q : best_val_q;
			end
			mmhq_pkg::S_SK_WP: begin
				we      = 1'b1;
				wr_addr = fixp_q;
			end
			mmhq_pkg::S_SK_FN: we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmhq_pkg::S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				mmhq_pkg::S_IDLE: if (start) begin
					ot_q <= '0;
					unique case (mmhq_pkg::func_t'(func))
						mmhq_pkg::FN_INS: if (cnt_q == CW'(mmhq_pkg::CAPACITY)) begin
							done_q <= 1'b1; res_status_q <= mmhq_pkg::ST_FULL;
							res_val_q <= '0; res_cnt_q <= cnt_q;
						end else begin
							x_q     <= {tag, score};
							pos_q   <= cnt_q[IW-1:0];
							cnt_q   <= cnt_q + CW'(1);
							state_q <= (cnt_q == '0) ? mmhq_pkg::S_CL_G : mmhq_pkg::S_CL_P;
						end
						mmhq_pkg::FN_DMIN, mmhq_pkg::FN_DMAX: if (cnt_q == '0) begin
							done_q <= 1'b1; res_status_q <= mmhq_pkg::ST_EMPTY;
							res_val_q <= '0; res_cnt_q <= cnt_q;
						end else if (func == mmhq_pkg::FN_DMAX && cnt_q >= CW'(3)) begin
							state_q <= mmhq_pkg::S_D_R1;
						end else begin
							hole_q  <= (func == mmhq_pkg::FN_DMAX && cnt_q == CW'(2))
							           ? IW'(1) : IW'(0);
							state_q <= mmhq_pkg::S_D_RH;
						end
						mmhq_pkg::FN_NOP: begin
							done_q <= 1'b1; res_status_q <= mmhq_pkg::ST_DONE;
							res_val_q <= '0; res_cnt_q <= cnt_q;
						end
					endcase
				end
				mmhq_pkg::S_CL_P: state_q <= mmhq_pkg::S_CL_PD;
				mmhq_pkg::S_CL_PD: begin
					if (beats) pos_q <= par_idx;
					mode_max_q <= beats ? mmhq_pkg::is_min_level(pos_q)
					                    : ~mmhq_pkg::is_min_level(pos_q);
					state_q <= mmhq_pkg::S_CL_G;
				end
				mmhq_pkg::S_CL_G: if (pos_q < IW'(3)) begin
					done_q <= 1'b1; res_status_q <= mmhq_pkg::ST_DONE;
					res_val_q <= ot_q; res_cnt_q <= cnt_q;
					state_q <= mmhq_pkg::S_IDLE;
				end else begin
					state_q <= mmhq_pkg::S_CL_GD;
				end
				mmhq_pkg::S_CL_GD: if (beats) begin
					pos_q   <= gp_idx;
					state_q <= mmhq_pkg::S_CL_G;
				end else begin
					done_q <= 1'b1; res_status_q <= mmhq_pkg::ST_DONE;
					res_val_q <= ot_q; res_cnt_q <= cnt_q;
					state_q <= mmhq_pkg::S_IDLE;
				end
				mmhq_pkg::S_D_R1: state_q <= mmhq_pkg::S_D_R2;
				mmhq_pkg::S_D_R2: begin
					k1_q    <= rd_data[31:0];
					state_q <= mmhq_pkg::S_D_C12;
				end
				mmhq_pkg::S_D_C12: begin
					hole_q  <= beats ? IW'(1) : IW'(2);
					state_q <= mmhq_pkg::S_D_RH;
				end
				mmhq_pkg::S_D_RH: state_q <= mmhq_pkg::S_D_HD;
				mmhq_pkg::S_D_HD: begin
					ot_q    <= rd_data;
					state_q <= mmhq_pkg::S_D_RL;
				end
				mmhq_pkg::S_D_RL: state_q <= mmhq_pkg::S_D_LD;
				mmhq_pkg::S_D_LD: begin
					x_q   <= rd_data;
					cnt_q <= cnt_q - CW'(1);
					pos_q <= hole_q;
					// hole was the tail itself: nothing left to sink
					if (CW'(hole_q) >= cnt_q - CW'(1)) begin
						done_q <= 1'b1; res_status_q <= mmhq_pkg::ST_DONE;
						res_val_q <= ot_q; res_cnt_q <= cnt_q - CW'(1);
						state_q <= mmhq_pkg::S_IDLE;
					end else begin
						state_q <= mmhq_pkg::S_SK_IN;
					end
				end
				mmhq_pkg::S_SK_IN: begin
					is_min_q    <= mmhq_pkg::is_min_level(pos_q);
					best_val_q  <= x_q;
					best_idx_q  <= pos_q;
					best_self_q <= 1'b1;
					best_k_q    <= '0;
					k_q         <= '0;
					state_q     <= mmhq_pkg::S_SK_RD;
				end
				// candidates rise in index: the first outside the heap ends the scan
				mmhq_pkg::S_SK_RD: state_q <= cand_in ? mmhq_pkg::S_SK_DT : mmhq_pkg::S_SK_DC;
				mmhq_pkg::S_SK_DT: begin
					if (k_q == 3'd0) ch0_q <= rd_data;
					if (k_q == 3'd1) ch1_q <= rd_data;
					if (beats) begin
						best_val_q  <= rd_data;
						best_idx_q  <= cand[IW-1:0];
						best_k_q    <= k_q;
						best_self_q <= 1'b0;
					end
					k_q     <= k_q + 3'd1;
					state_q <= (k_q == 3'd5) ? mmhq_pkg::S_SK_DC : mmhq_pkg::S_SK_RD;
				end
				mmhq_pkg::S_SK_DC: if (best_self_q) begin
					done_q <= 1'b1; res_status_q <= mmhq_pkg::ST_DONE;
					res_val_q <= ot_q; res_cnt_q <= cnt_q;
					state_q <= mmhq_pkg::S_IDLE;
				end else begin
					pos_q <= best_idx_q;
					if (best_k_q < 3'd2) begin
						state_q <= mmhq_pkg::S_SK_FN;
					end else if (beats) begin
						// grandchild fix-up: moving word trades places with its new parent
						fixp_q  <= (best_idx_q - IW'(1)) >> 1;
						fixv_q  <= par_val;
						state_q <= mmhq_pkg::S_SK_WP;
					end else begin
						state_q <= mmhq_pkg::S_SK_IN;
					end
				end
				mmhq_pkg::S_SK_WP: begin
					x_q     <= fixv_q;
					state_q <= mmhq_pkg::S_SK_IN;
				end
				mmhq_pkg::S_SK_FN: begin
					done_q <= 1'b1; res_status_q <= mmhq_pkg::ST_DONE;
					res_val_q <= ot_q; res_cnt_q <= cnt_q;
					state_q <= mmhq_pkg::S_IDLE;
				end
				default: state_q <= mmhq_pkg::S_IDLE;
			endcase
		end
	end

	assign busy      = state_q != mmhq_pkg::S_IDLE;
	assign done      = done_q;
	assign status    = res_status_q;
	assign out_tag   = res_val_q[63:32];
	assign out_score = res_val_q[31:0];
	assign count     = 8'(res_cnt_q);
endmodule
`default_nettype wire

>>> rtl/mmhq_ram.sv
`default_nettype none
module mmhq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[wr_addr] <= wr_data;
		rd_data <= mem_q[rd_addr];
	end
endmodule
`default_nettype wire

>>> rtl/mmhq_cmp.sv
`default_nettype none
module mmhq_cmp (
	input  wire logic signed [31:0] a,
	input  wire logic signed [31:0] b,
	input  wire logic               want_max,
	output logic                    beats
);
	// strict: a ties never win
	assign beats = want_max ? (a > b) : (a < b);
endmodule
`default_nettype wire

>>> rtl/mmhq_chk.sv
`default_nettype none
`include "min_max_heap_queue_macros.svh"
module mmhq_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [1:0]  status,
	input wire logic [31:0] out_tag,
	input wire logic [31:0] out_score,
	input wire logic [7:0]  count
);
	`MMHQ_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy)
	`MMHQ_ASSERT_NEXT(a_start_moves, clk, arst_n, start && !busy, busy || done)
	`MMHQ_ASSERT_NOW(a_count_cap, clk, arst_n, done, count <= 8'(mmhq_pkg::CAPACITY))
	`MMHQ_ASSERT_NOW(a_refused_zero, clk, arst_n, done && status != mmhq_pkg::ST_DONE,
		out_tag == 32'd0 && out_score == 32'd0)
endmodule

bind min_max_heap_queue mmhq_chk u_chk (.*);
`default_nettype wire
